// ===== design/refcounted_slot_cache_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the refcounted slot cache
// Shared wrappers for concurrent checks clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_SLOT_CACHE_TOP_MACROS_SVH
`define REFCOUNTED_SLOT_CACHE_TOP_MACROS_SVH

// Same-cycle implication check.
`define RSC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check.
`define RSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Refcounted slot cache package
// Field widths, stream packing widths and result status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rsc_pkg;

  // Payload field widths.
  localparam int KEY_W    = 32;
  localparam int IDX_W    = 8;
  localparam int STATUS_W = 3;

  // Stream data widths, padded to whole bytes.
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  // Command codes carried on in_tuser.
  localparam logic CMD_RETRIEVE = 1'b0;
  localparam logic CMD_RELEASE  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ALLOC     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOFREE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BUILDFAIL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd4;

endpackage

// ===== design/rsc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/refcounted_slot_cache_top.sv =====
// A retrieve scans the slot RAM for its key, starting at slot 0, and a hit ends the scan;
// a miss runs a full key scan, then the free scan from the slot after the last pick.
// A release reads the slot word, then decrements its count; indices >= SLOTS skip both.
// One item is in work at a time; the serial scans of the slot RAM read port set the rate.
// After reset the whole slot RAM is cleared, one entry a cycle, before input is taken.
// ----------------------------------------------------------------------------
// Refcounted slot cache, top level
// Keyed slot cache with reference counts and round-robin allocation, with
// key, valid bit and count of every slot held in one RAM word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "refcounted_slot_cache_top_macros.svh"

module refcounted_slot_cache_top
  import rsc_pkg::*;
#(
  parameter int SLOTS      = 256,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // lookup_key[31:0], slot_index[39:32],
                                            // build_ok[40], zero pad [47:41]
  input  logic                  in_tuser,   // cmd[0]
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // status[2:0], slot_out[10:3], zero pad [15:11]
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = IW + 1;
  localparam int DW = KEY_W + 1 + COUNT_BITS;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HIT   = 6'b000100,
    S_FREE  = 6'b001000,
    S_REL   = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  // Control registers.
  state_t                state_r, state_nxt;
  logic [IW-1:0]         ptr_r, ptr_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]         last_r, last_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  build_r, build_nxt;
  logic [IW-1:0]         chk_addr_r, chk_addr_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [IDX_W-1:0]      res_slot_r, res_slot_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [IDX_W-1:0]      out_slot_r, out_slot_nxt;

  // RAM ports.
  logic                  mem_we;
  logic [IW-1:0]         mem_waddr;
  logic [DW-1:0]         mem_wdata;
  logic                  mem_re;
  logic [IW-1:0]         mem_raddr;
  logic [DW-1:0]         mem_rdata;

  // Fields of the word read back.
  logic [KEY_W-1:0]      rd_key;
  logic                  rd_valid;
  logic [COUNT_BITS-1:0] rd_count;
  logic                  issue;
  logic                  in_fire;
  logic                  out_load;
  logic                  rel_in_range;

  rsc_ram #(
    .WIDTH (DW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Next slot index in round-robin order.
  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] a);
    logic [IW-1:0] n;
    if (a == IW'(SLOTS - 1)) begin
      n = '0;
    end else begin
      n = a + 1'b1;
    end
    return n;
  endfunction

  assign rd_count = mem_rdata[COUNT_BITS-1:0];
  assign rd_valid = mem_rdata[COUNT_BITS];
  assign rd_key   = mem_rdata[DW-1:COUNT_BITS+1];

  assign in_tready    = (state_r == S_IDLE);
  assign in_fire      = in_tvalid && in_tready;
  assign issue        = (cnt_r < CW'(SLOTS));
  assign rel_in_range = (32'(idx_r) < 32'(SLOTS));
  assign out_load     = (state_r == S_RESP) && (!out_valid_r || out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - STATUS_W - IDX_W){1'b0}}, out_slot_r, out_status_r};

  // Sequencer: clearing pass, key scan, free scan, release and result hand-off.
  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    cnt_nxt        = cnt_r;
    chk_vld_nxt    = 1'b0;
    chk_addr_nxt   = chk_addr_r;
    last_nxt       = last_r;
    key_nxt        = key_r;
    idx_nxt        = idx_r;
    build_nxt      = build_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    mem_we         = 1'b0;
    mem_waddr      = chk_addr_r;
    mem_wdata      = mem_rdata;
    mem_re         = 1'b0;
    mem_raddr      = ptr_r;

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = '0;
        ptr_nxt   = next_slot(ptr_r);
        if (ptr_r == IW'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          key_nxt   = in_tdata[KEY_W-1:0];
          idx_nxt   = in_tdata[KEY_W+IDX_W-1:KEY_W];
          build_nxt = in_tdata[KEY_W+IDX_W];
          ptr_nxt   = '0;
          cnt_nxt   = '0;
          if (in_tuser == CMD_RETRIEVE) begin
            state_nxt = S_HIT;
          end else begin
            state_nxt = S_REL;
          end
        end
      end

      S_HIT: begin
        // Keep one read in flight and check the previous one.
        mem_re       = issue;
        chk_vld_nxt  = issue;
        chk_addr_nxt = ptr_r;
        ptr_nxt      = next_slot(ptr_r);
        cnt_nxt      = cnt_r + 1'b1;
        if (chk_vld_r && rd_valid && (rd_key == key_r)) begin
          mem_we = 1'b1;
          if (rd_count != '1) begin
            mem_wdata[COUNT_BITS-1:0] = rd_count + 1'b1;
          end
          res_status_nxt = ST_HIT;
          res_slot_nxt   = IDX_W'(chk_addr_r);
          chk_vld_nxt    = 1'b0;
          state_nxt      = S_RESP;
        end else if (!chk_vld_r && !issue) begin
          // No key matched: start the free scan after the last slot picked.
          chk_vld_nxt = 1'b0;
          cnt_nxt     = '0;
          ptr_nxt     = next_slot(last_r);
          state_nxt   = S_FREE;
        end
      end

      S_FREE: begin
        mem_re       = issue;
        chk_vld_nxt  = issue;
        chk_addr_nxt = ptr_r;
        ptr_nxt      = next_slot(ptr_r);
        cnt_nxt      = cnt_r + 1'b1;
        if (chk_vld_r && (rd_count == '0)) begin
          last_nxt    = chk_addr_r;
          chk_vld_nxt = 1'b0;
          state_nxt   = S_RESP;
          if (build_r) begin
            mem_we         = 1'b1;
            mem_wdata      = {key_r, 1'b1, COUNT_BITS'(1)};
            res_status_nxt = ST_ALLOC;
            res_slot_nxt   = IDX_W'(chk_addr_r);
          end else begin
            res_status_nxt = ST_BUILDFAIL;
            res_slot_nxt   = '0;
          end
        end else if (!chk_vld_r && !issue) begin
          chk_vld_nxt    = 1'b0;
          res_status_nxt = ST_NOFREE;
          res_slot_nxt   = '0;
          state_nxt      = S_RESP;
        end
      end

      S_REL: begin
        res_status_nxt = ST_RELEASED;
        res_slot_nxt   = idx_r;
        if (!rel_in_range) begin
          state_nxt = S_RESP;
        end else if (!chk_vld_r) begin
          // Read the slot's word first.
          mem_re       = 1'b1;
          mem_raddr    = IW'(idx_r);
          chk_vld_nxt  = 1'b1;
          chk_addr_nxt = IW'(idx_r);
        end else begin
          // Decrement, saturating at zero.
          mem_we = (rd_count != '0);
          mem_wdata[COUNT_BITS-1:0] = rd_count - 1'b1;
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_slot_nxt   = res_slot_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ptr_r       <= '0;
      cnt_r       <= '0;
      chk_vld_r   <= 1'b0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      chk_vld_r   <= chk_vld_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload state.
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    idx_r        <= idx_nxt;
    build_r      <= build_nxt;
    chk_addr_r   <= chk_addr_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  // Checks.
  `RSC_ASSERT_IMPL(a_idle_no_read, state_r == S_IDLE, !chk_vld_r,
                   "read still being checked while idle")
  `RSC_ASSERT_IMPL(a_alloc_is_last, (state_r == S_RESP) && (res_status_r == ST_ALLOC),
                   res_slot_r == IDX_W'(last_r), "allocated slot differs from last allocated")
  `RSC_ASSERT_IMPL(a_status_code, out_valid_r, out_status_r <= ST_RELEASED,
                   "result status out of range")
  `RSC_ASSERT_NEXT(a_hit_write_done, mem_we && (state_r == S_HIT), state_r == S_RESP,
                   "key scan kept running after its count update")

endmodule

// ===== tb/refcounted_slot_cache_top_tb.sv =====
// ----------------------------------------------------------------------------
// Refcounted slot cache testbench
// Drives retrieve and release transactions into the cache, predicts each
// result with a behavioral copy of the slot table, and compares every
// result transaction field by field. The run builds up one reference count,
// covers the directed corner cases, fills the table until no slot is free,
// and finishes with random traffic under random input gaps and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module refcounted_slot_cache_top_tb;
  import rsc_pkg::*;

  localparam int SLOTS       = 256;
  localparam int COUNT_BITS  = 16;
  localparam int RANDOM_OPS  = 850;
  localparam int HOT_HITS    = 20;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [KEY_W-1:0] HOT_KEY = 32'h0000_BEEF;

  typedef struct packed {
    logic             cmd;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
    logic             build_ok;
  } cache_request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    slot;
  } cache_result_t;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PAIRS, RX_SPARSE} rx_mode_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Shadow copy of the slot table.
  logic [KEY_W-1:0]      cached_key [SLOTS];
  bit                    key_valid  [SLOTS];
  logic [COUNT_BITS-1:0] ref_cnt    [SLOTS];
  logic [IDX_W-1:0]      alloc_ptr;

  cache_request_t pending_requests[$];
  cache_result_t  expected_results[$];
  cache_request_t next_request;
  cache_result_t  want;

  int  requests_queued   = 0;
  int  requests_sent     = 0;
  int  requests_accepted = 0;
  int  error_count       = 0;
  bit  no_idle           = 1'b0;
  int  burst_left        = 0;
  int  gap_left          = 0;
  int  rx_left           = 0;
  rx_mode_t rx_mode      = RX_OPEN;

  refcounted_slot_cache_top #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // lookup_key[31:0], slot_index[39:32], build_ok[40], pad
    .in_tuser   (in_tuser),   // cmd[0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)   // status[2:0], slot_out[10:3], pad
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Applies one accepted request to the shadow table and returns its result.
  function automatic cache_result_t predict_access(input cache_request_t req);
    cache_result_t res;
    int            hit_slot;
    int            free_slot;
    int            id;
    res.status = ST_RELEASED;
    res.slot   = req.idx;
    if (req.cmd == CMD_RELEASE) begin
      if (ref_cnt[req.idx] != '0) begin
        ref_cnt[req.idx] = ref_cnt[req.idx] - 1'b1;
      end
      return res;
    end
    // The lowest valid slot holding the key is the hit.
    hit_slot = -1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (key_valid[i] && cached_key[i] == req.key) begin
        hit_slot = i;
      end
    end
    if (hit_slot >= 0) begin
      if (ref_cnt[hit_slot] != COUNT_MAX) begin
        ref_cnt[hit_slot] = ref_cnt[hit_slot] + 1'b1;
      end
      res.status = ST_HIT;
      res.slot   = hit_slot[IDX_W-1:0];
      return res;
    end
    // Round-robin search for an unreferenced slot, starting after the last pick.
    free_slot = -1;
    for (int step = SLOTS; step >= 1; step--) begin
      id = (alloc_ptr + step) % SLOTS;
      if (ref_cnt[id] == '0) begin
        free_slot = id;
      end
    end
    res.slot = '0;
    if (free_slot < 0) begin
      res.status = ST_NOFREE;
    end else begin
      alloc_ptr = free_slot[IDX_W-1:0];
      if (!req.build_ok) begin
        res.status = ST_BUILDFAIL;
      end else begin
        cached_key[free_slot] = req.key;
        key_valid[free_slot]  = 1'b1;
        ref_cnt[free_slot]    = COUNT_BITS'(1);
        res.status = ST_ALLOC;
        res.slot   = free_slot[IDX_W-1:0];
      end
    end
    return res;
  endfunction

  // Queues one request and returns once the cache has accepted it.
  task automatic send_request(input logic cmd, input logic [KEY_W-1:0] key,
                              input logic [IDX_W-1:0] idx, input logic build_ok);
    cache_request_t req;
    req.cmd      = cmd;
    req.key      = key;
    req.idx      = idx;
    req.build_ok = build_ok;
    pending_requests.push_back(req);
    requests_queued++;
    wait (requests_accepted == requests_queued);
  endtask

  // Input driver: bursts of transactions separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && requests_accepted != requests_sent) begin
      // Hold the current transaction until it is taken.
    end else if (gap_left > 0 && !no_idle) begin
      in_tvalid <= 1'b0;
      gap_left  <= gap_left - 1;
    end else if (pending_requests.size() > 0) begin
      next_request = pending_requests.pop_front();
      in_tvalid    <= 1'b1;
      in_tuser     <= next_request.cmd;
      in_tdata     <= {7'b0, next_request.build_ok, next_request.idx, next_request.key};
      requests_sent <= requests_sent + 1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 20);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 :
                      ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) :
                                                    $urandom_range(1, 8);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Result receiver: stalls follow a randomly picked mode, and a new mode is picked when its run ends.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (no_idle) begin
      out_tready <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_left <= $urandom_range(8, 60);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_RANDOM: out_tready <= ($urandom_range(0, 99) >= 35);
        RX_PAIRS:  out_tready <= rx_left[1];
        default:   out_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Monitor: predicts on every accepted request and checks every result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: result with none expected: status %0d slot %0d",
                   $time, out_tdata[2:0], out_tdata[10:3]);
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[2:0] !== want.status) begin
            error_count++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_tdata[2:0]);
          end
          if (out_tdata[10:3] !== want.slot) begin
            error_count++;
            $display("%0t: slot mismatch: expected %0d, actual %0d",
                     $time, want.slot, out_tdata[10:3]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        next_request.cmd      = in_tuser;
        next_request.key      = in_tdata[31:0];
        next_request.idx      = in_tdata[39:32];
        next_request.build_ok = in_tdata[40];
        expected_results.push_back(predict_access(next_request));
        requests_accepted = requests_accepted + 1;
      end
    end
  end

  // Stimulus sequence and end of run.
  initial begin : stimulus
    logic [KEY_W-1:0] key_pool [300];
    int               roll;
    int               start;
    int               busy_slot;
    int               id;

    for (int i = 0; i < SLOTS; i++) begin
      cached_key[i] = '0;
      key_valid[i]  = 1'b0;
      ref_cnt[i]    = '0;
    end
    alloc_ptr = '0;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 300; i++) begin
      key_pool[i] = $urandom;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Build up the count of slot 1, the first slot allocated after reset.
    no_idle = 1'b1;
    send_request(CMD_RETRIEVE, HOT_KEY, 8'd0, 1'b1);
    for (int i = 0; i < HOT_HITS; i++) begin
      send_request(CMD_RETRIEVE, HOT_KEY, IDX_W'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
    end
    wait (expected_results.size() == 0);
    no_idle = 1'b0;

    // Directed corner cases.
    send_request(CMD_RELEASE, 32'h0, 8'd0, 1'b1);           // release of an idle slot
    send_request(CMD_RELEASE, 32'hFFFF_FFFF, 8'd255, 1'b0);
    send_request(CMD_RETRIEVE, 32'h0, 8'd0, 1'b0);          // build failure
    send_request(CMD_RETRIEVE, 32'h0, 8'd255, 1'b1);
    send_request(CMD_RETRIEVE, 32'hFFFF_FFFF, 8'd0, 1'b1);
    send_request(CMD_RETRIEVE, 32'h0, 8'd0, 1'b0);          // hit ignores build_ok
    send_request(CMD_RELEASE, 32'h0, 8'd3, 1'b0);
    send_request(CMD_RELEASE, 32'h0, 8'd3, 1'b1);
    send_request(CMD_RELEASE, 32'h0, 8'd3, 1'b0);           // count already zero
    send_request(CMD_RETRIEVE, 32'h0, 8'd0, 1'b1);          // hit on an unreferenced slot
    send_request(CMD_RETRIEVE, 32'hFFFF_FFFF, 8'd0, 1'b1);
    send_request(CMD_RETRIEVE, HOT_KEY, 8'd0, 1'b1);        // hit on a hot slot
    send_request(CMD_RELEASE, 32'h0, 8'd1, 1'b0);
    send_request(CMD_RETRIEVE, 32'h8000_0001, 8'd128, 1'b1);
    send_request(CMD_RETRIEVE, 32'h7FFF_FFFE, 8'd127, 1'b0);

    // Fill every slot, then run into the full table.
    for (int i = 0; i < 262; i++) begin
      send_request(CMD_RETRIEVE, 32'hA5A5_0000 + i, IDX_W'($urandom_range(0, 255)),
                   (i % 37) != 36);
    end
    send_request(CMD_RELEASE, 32'h0, 8'd200, 1'b1);
    send_request(CMD_RETRIEVE, 32'h1234_5678, 8'd0, 1'b1);

    // Random traffic, mostly hot keys and releases of referenced slots.
    for (int n = 0; n < RANDOM_OPS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
        send_request(CMD_RETRIEVE, key_pool[$urandom_range(0, 47)],
                     IDX_W'($urandom_range(0, 255)), $urandom_range(0, 9) != 0);
      end else if (roll < 40) begin
        send_request(CMD_RETRIEVE, key_pool[$urandom_range(0, 299)],
                     IDX_W'($urandom_range(0, 255)), $urandom_range(0, 9) != 0);
      end else if (roll < 45) begin
        send_request(CMD_RETRIEVE, $urandom, IDX_W'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
      end else if (roll < 92) begin
        start     = $urandom_range(0, SLOTS - 1);
        busy_slot = start;
        for (int k = SLOTS - 1; k >= 0; k--) begin
          id = (start + k) % SLOTS;
          if (ref_cnt[id] != '0) begin
            busy_slot = id;
          end
        end
        send_request(CMD_RELEASE, $urandom, busy_slot[IDX_W-1:0],
                     1'($urandom_range(0, 1)));
      end else begin
        send_request(CMD_RELEASE, $urandom, IDX_W'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
      end
    end

    // Drain, then allow for a full two-pass scan.
    wait (expected_results.size() == 0);
    repeat (2 * SLOTS + 8) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #300_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/rsc_pkg.sv
design/rsc_ram.sv
design/refcounted_slot_cache_top.sv
tb/refcounted_slot_cache_top_tb.sv
